// File: hdl/rsi_pkg.sv
package rsi_pkg;

  localparam int FRAC_BITS = 16;

  localparam int CW      = 32;
  localparam int RW      = 31;
  localparam int OCW     = CW + 1;
  localparam int PD_W    = CW + OCW;
  localparam int PS_W    = 2 * OCW;
  localparam int R2_W    = 2 * RW;
  localparam int DOT_W   = PD_W + 2;
  localparam int CT_W    = PS_W + 2;
  localparam int H_W     = DOT_W - FRAC_BITS;
  localparam int HL_W    = (H_W + 1) / 2;
  localparam int HH_W    = H_W - HL_W;
  localparam int HSQ_W   = 2 * H_W;
  localparam int DISC_W  = HSQ_W + 2;
  localparam int S_W     = H_W;
  localparam int V_W     = 2 * S_W;
  localparam int T_W     = H_W + 2;
  localparam int PR_W    = 2 * CW;
  localparam int SUM_W   = PR_W - FRAC_BITS + 1;

  localparam int QDEPTH  = 4;
  localparam int QA_W    = 2;

  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = CFG_IDX_W'(3);

  localparam logic [RW-1:0] RADIUS_RESET = RW'(1) << FRAC_BITS;
  localparam logic [RW-1:0] DIST_MAX     = {RW{1'b1}};

  localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [2:0][CW-1:0] o;
    logic [2:0][CW-1:0] d;
    logic [H_W-1:0]     h;
    logic               neg;
  } side_t;

  typedef struct packed {
    logic               hit;
    logic [RW-1:0]      tdist;
    logic [2:0][CW-1:0] o;
    logic [2:0][CW-1:0] d;
  } qent_t;

  function automatic logic [CW-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic [CW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[CW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/ray_sphere_intersect.sv
// Ray against one sphere, Q16.16 fixed point. Centre and radius are set through the
// configuration port (cfg_index 0..2 centre x/y/z, 3 radius; other indexes ignored), and
// should only change while no ray is in flight. Every accepted ray yields exactly one result:
// the hit flag, the nearest strictly positive distance (saturated), the hit point and the
// unnormalized normal; a miss returns all zeros. One ray is accepted per clock unless the
// front pipeline is held by a full queue. The front pipeline holds the 51-stage square-root
// pipeline; stalls on the output hold the back end. A four-entry queue separates the
// classifying front pipeline from the hit-point back end.
module ray_sphere_intersect import rsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] origin_x,
  input  logic signed [CW-1:0] origin_y,
  input  logic signed [CW-1:0] origin_z,
  input  logic signed [CW-1:0] dir_x,
  input  logic signed [CW-1:0] dir_y,
  input  logic signed [CW-1:0] dir_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [RW-1:0]        distance,
  output logic signed [CW-1:0] hit_x,
  output logic signed [CW-1:0] hit_y,
  output logic signed [CW-1:0] hit_z,
  output logic signed [CW-1:0] normal_x,
  output logic signed [CW-1:0] normal_y,
  output logic signed [CW-1:0] normal_z
);

  logic [2:0][CW-1:0] center;
  logic [RW-1:0]      radius;
  logic [2:0][CW-1:0] in_o, in_d, hit_p, normal;
  logic               q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  qent_t              q_in_data, q_out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0;
      radius <= RADIUS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X: center[0] <= cfg_data;
        REG_CENTER_Y: center[1] <= cfg_data;
        REG_CENTER_Z: center[2] <= cfg_data;
        REG_RADIUS:   radius    <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  assign in_o = {origin_z, origin_y, origin_x};
  assign in_d = {dir_z, dir_y, dir_x};

  rsi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_o     (in_o),
    .in_d     (in_d),
    .center   (center),
    .radius   (radius),
    .q_valid  (q_in_valid),
    .q_ready  (q_in_ready),
    .q_data   (q_in_data)
  );

  rsi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_data   (q_in_data),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_data  (q_out_data)
  );

  rsi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_out_valid),
    .q_ready   (q_out_ready),
    .q_data    (q_out_data),
    .center    (center),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .distance  (distance),
    .hit_p     (hit_p),
    .normal    (normal)
  );

  assign hit_x    = hit_p[0];
  assign hit_y    = hit_p[1];
  assign hit_z    = hit_p[2];
  assign normal_x = normal[0];
  assign normal_y = normal[1];
  assign normal_z = normal[2];

endmodule

// File: hdl/rsi_sqrt.sv
module rsi_sqrt import rsi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [V_W-1:0]   in_val,
  input  side_t            in_side,
  output logic             out_vld,
  output logic [S_W-1:0]   out_root,
  output side_t            out_side
);

  logic           st_vld  [S_W];
  logic [V_W-1:0] st_rem  [S_W];
  logic [S_W-1:0] st_q    [S_W];
  side_t          st_side [S_W];

  // one root bit per stage, MSB first
  for (genvar k = 0; k < S_W; k++) begin : g_stage
    localparam int B = S_W - 1 - k;
    logic           pv;
    logic [V_W-1:0] prem;
    logic [S_W-1:0] pq;
    side_t          pside;
    logic [V_W-1:0] trial;
    logic           take;

    if (k == 0) begin : g_first
      assign pv    = in_vld;
      assign prem  = in_val;
      assign pq    = '0;
      assign pside = in_side;
    end else begin : g_rest
      assign pv    = st_vld[k-1];
      assign prem  = st_rem[k-1];
      assign pq    = st_q[k-1];
      assign pside = st_side[k-1];
    end

    assign trial = (V_W'(pq) << (B + 1)) | (V_W'(1) << (2 * B));
    assign take  = prem >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[k] <= 1'b0;
      end else if (en) begin
        st_vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[k]  <= take ? prem - trial : prem;
        st_q[k]    <= take ? (pq | (S_W'(1) << B)) : pq;
        st_side[k] <= pside;
      end
    end
  end

  assign out_vld  = st_vld[S_W-1];
  assign out_root = st_q[S_W-1];
  assign out_side = st_side[S_W-1];

endmodule

// File: hdl/rsi_front.sv
module rsi_front import rsi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0][CW-1:0] in_o,
  input  logic [2:0][CW-1:0] in_d,
  input  logic [2:0][CW-1:0] center,
  input  logic [RW-1:0]      radius,
  output logic               q_valid,
  input  logic               q_ready,
  output qent_t              q_data
);

  logic en;

  logic a_vld, b_vld, c_vld, e_vld, f_vld, g_vld, k_vld, t_vld, u_vld;

  logic [2:0][CW-1:0] a_o, a_d, b_o, b_d, c_o, c_d, e_o, e_d, f_o, f_d, g_o, g_d;
  logic signed [OCW-1:0]   a_oc [3];
  logic signed [PD_W-1:0]  b_pd [3];
  logic signed [PS_W-1:0]  b_ps [3];
  logic [R2_W-1:0]         b_r2;
  logic signed [DOT_W-1:0] dot;
  logic signed [H_W-1:0]   c_h, e_h, f_h, g_h;
  logic signed [CT_W-1:0]  c_ct, e_ct, f_ct, g_ct;
  logic [H_W-1:0]          e_hmag;
  logic [2*HL_W-1:0]       f_p0;
  logic [HH_W+HL_W-1:0]    f_p1;
  logic [2*HH_W-1:0]       f_p2;
  logic [HSQ_W-1:0]        g_hsq;
  logic signed [DISC_W-1:0] disc;
  logic [V_W-1:0]          k_val;
  side_t                   k_side;

  logic                    s_vld;
  logic [S_W-1:0]          s_root;
  side_t                   s_side;
  logic signed [T_W-1:0]   hx, sx;
  logic signed [T_W-1:0]   t_t1, t_t2, tsel;
  side_t                   t_side;
  logic                    pos1, pos2, hit;
  qent_t                   u_ent, u_ent_next;

  assign en       = !u_vld || q_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
      k_vld <= 1'b0;
      t_vld <= 1'b0;
      u_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
      e_vld <= c_vld;
      f_vld <= e_vld;
      g_vld <= f_vld;
      k_vld <= g_vld;
      t_vld <= s_vld;
      u_vld <= t_vld;
    end
  end

  assign dot = DOT_W'(b_pd[0]) + DOT_W'(b_pd[1]) + DOT_W'(b_pd[2]);
  assign disc = $signed(DISC_W'(g_hsq)) - DISC_W'(g_ct);

  always_ff @(posedge clk) begin
    if (en) begin
      a_o <= in_o;
      a_d <= in_d;
      for (int i = 0; i < 3; i++) begin
        a_oc[i] <= OCW'($signed(in_o[i])) - OCW'($signed(center[i]));
      end

      b_o <= a_o;
      b_d <= a_d;
      for (int i = 0; i < 3; i++) begin
        b_pd[i] <= PD_W'($signed(a_d[i])) * PD_W'(a_oc[i]);
        b_ps[i] <= PS_W'(a_oc[i]) * PS_W'(a_oc[i]);
      end
      b_r2 <= R2_W'(radius) * R2_W'(radius);

      c_o  <= b_o;
      c_d  <= b_d;
      c_h  <= H_W'(dot >>> FRAC_BITS);
      c_ct <= CT_W'(b_ps[0]) + CT_W'(b_ps[1]) + CT_W'(b_ps[2]) - $signed(CT_W'(b_r2));

      e_o    <= c_o;
      e_d    <= c_d;
      e_h    <= c_h;
      e_ct   <= c_ct;
      e_hmag <= c_h[H_W-1] ? H_W'(-c_h) : H_W'(c_h);

      f_o  <= e_o;
      f_d  <= e_d;
      f_h  <= e_h;
      f_ct <= e_ct;
      f_p0 <= (2*HL_W)'(e_hmag[HL_W-1:0]) * (2*HL_W)'(e_hmag[HL_W-1:0]);
      f_p1 <= (HH_W+HL_W)'(e_hmag[H_W-1:HL_W]) * (HH_W+HL_W)'(e_hmag[HL_W-1:0]);
      f_p2 <= (2*HH_W)'(e_hmag[H_W-1:HL_W]) * (2*HH_W)'(e_hmag[H_W-1:HL_W]);

      g_o   <= f_o;
      g_d   <= f_d;
      g_h   <= f_h;
      g_ct  <= f_ct;
      g_hsq <= (HSQ_W'(f_p2) << (2 * HL_W)) + (HSQ_W'(f_p1) << (HL_W + 1)) + HSQ_W'(f_p0);

      k_side.o   <= g_o;
      k_side.d   <= g_d;
      k_side.h   <= g_h;
      k_side.neg <= disc[DISC_W-1];
      k_val      <= disc[DISC_W-1] ? '0 : disc[V_W-1:0];

      t_t1   <= -hx - sx;
      t_t2   <= -hx + sx;
      t_side <= s_side;

      u_ent <= u_ent_next;
    end
  end

  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (k_vld),
    .in_val   (k_val),
    .in_side  (k_side),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_side (s_side)
  );

  assign hx = T_W'($signed(s_side.h));
  assign sx = $signed(T_W'(s_root));

  always_comb begin
    pos1 = t_t1 > 0;
    pos2 = t_t2 > 0;
    hit  = !t_side.neg && (pos1 || pos2);
    tsel = pos1 ? t_t1 : t_t2;
    u_ent_next.hit = hit;
    u_ent_next.o   = t_side.o;
    u_ent_next.d   = t_side.d;
    if (!hit) begin
      u_ent_next.tdist = '0;
    end else if (tsel > $signed({{(T_W-RW){1'b0}}, DIST_MAX})) begin
      u_ent_next.tdist = DIST_MAX;
    end else begin
      u_ent_next.tdist = tsel[RW-1:0];
    end
  end

  assign q_valid = u_vld;
  assign q_data  = u_ent;

endmodule

// File: hdl/rsi_queue.sv
module rsi_queue import rsi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  qent_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output qent_t out_data
);

  qent_t           mem [QDEPTH];
  logic [QA_W-1:0] wr_ptr, rd_ptr;
  logic [QA_W:0]   count;
  logic            push, pop;

  assign in_ready  = count != (QA_W+1)'(QDEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QA_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QA_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

// File: hdl/rsi_back.sv
module rsi_back import rsi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  qent_t              q_data,
  input  logic [2:0][CW-1:0] center,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [RW-1:0]      distance,
  output logic [2:0][CW-1:0] hit_p,
  output logic [2:0][CW-1:0] normal
);

  logic en;
  logic p_vld, h_vld, n_vld;

  logic                    p_hit, h_hit;
  logic [RW-1:0]           p_dist, h_dist;
  logic [2:0][CW-1:0]      p_o;
  logic signed [PR_W-1:0]  p_prod [3];
  logic [2:0][CW-1:0]      h_hp;
  logic [2:0][CW-1:0]      n_hp, n_nrm;
  logic                    n_hit;
  logic [RW-1:0]           n_dist;

  assign en      = !n_vld || out_ready;
  assign q_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      h_vld <= 1'b0;
      n_vld <= 1'b0;
    end else if (en) begin
      p_vld <= q_valid;
      h_vld <= p_vld;
      n_vld <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_hit  <= q_data.hit;
      p_dist <= q_data.tdist;
      p_o    <= q_data.o;
      for (int i = 0; i < 3; i++) begin
        p_prod[i] <= PR_W'($signed({1'b0, q_data.tdist})) * PR_W'($signed(q_data.d[i]));
      end

      h_hit  <= p_hit;
      h_dist <= p_dist;
      for (int i = 0; i < 3; i++) begin
        h_hp[i] <= p_hit ? sat_coord(SUM_W'($signed(p_o[i])) + SUM_W'(p_prod[i] >>> FRAC_BITS))
                         : '0;
      end

      n_hit  <= h_hit;
      n_dist <= h_dist;
      n_hp   <= h_hp;
      for (int i = 0; i < 3; i++) begin
        n_nrm[i] <= h_hit ? sat_coord(SUM_W'($signed(h_hp[i])) - SUM_W'($signed(center[i])))
                          : '0;
      end
    end
  end

  assign out_valid = n_vld;
  assign hit       = n_hit;
  assign distance  = n_dist;
  assign hit_p     = n_hp;
  assign normal    = n_nrm;

endmodule

// File: hdl/rsi_checker.sv
module rsi_checker import rsi_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 hit,
  input logic [RW-1:0]        distance,
  input logic signed [CW-1:0] hit_x,
  input logic signed [CW-1:0] hit_y,
  input logic signed [CW-1:0] hit_z,
  input logic signed [CW-1:0] normal_x,
  input logic signed [CW-1:0] normal_y,
  input logic signed [CW-1:0] normal_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(distance)
      && $stable(hit_x) && $stable(normal_x))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> distance == '0 && hit_x == '0 && hit_y == '0 && hit_z == '0
      && normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("miss with nonzero fields");

  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> distance != '0)
    else $error("hit with zero distance");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);

// File: tb/tb_ray_sphere_intersect.sv
module tb_ray_sphere_intersect;
  import rsi_pkg::*;

  typedef logic signed [159:0] wide_t;
  typedef enum logic [1:0] {OP_RAY, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t               kind;
    logic signed [CW-1:0]   o [3];
    logic signed [CW-1:0]   d [3];
    logic [CFG_IDX_W-1:0]   idx;
    logic [CW-1:0]          data;
  } op_t;

  typedef struct {
    logic          hit;
    logic [RW-1:0] tdist;
    logic [CW-1:0] hp [3];
    logic [CW-1:0] nrm [3];
  } hit_rec_t;

  localparam wide_t I32_MAX = 160'sh7FFFFFFF;
  localparam wide_t I32_MIN = -I32_MAX - 1;
  localparam int QUIET_CYC = 80;
  localparam int STALL_LIMIT = 3000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic signed [CW-1:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [CW-1:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic out_valid, out_ready = 0;
  logic hit;
  logic [RW-1:0] distance;
  logic signed [CW-1:0] hit_x, hit_y, hit_z, normal_x, normal_y, normal_z;

  ray_sphere_intersect dut (.*);

  initial forever #5 clk = ~clk;

  op_t pending [$];
  hit_rec_t expected_hits [$];
  int errors = 0;

  // sphere as the predictor sees it
  logic signed [CW-1:0] sph_c [3] = '{0, 0, 0};
  logic [RW-1:0] sph_r = RADIUS_RESET;

  // sphere as planned while filling the stimulus
  real plan_c [3] = '{0.0, 0.0, 0.0};
  real plan_r = 65536.0;

  function automatic wide_t sat32(wide_t v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  function automatic hit_rec_t trace_ray(op_t ray);
    hit_rec_t res;
    wide_t oc, dot, len2, rr, h, disc, s, cand, t1, t2, t, tdist, hp;
    dot = 0;
    len2 = 0;
    res.hit = 0;
    res.tdist = '0;
    for (int i = 0; i < 3; i++) begin
      res.hp[i] = '0;
      res.nrm[i] = '0;
      oc = ray.o[i];
      oc = oc - sph_c[i];
      dot = dot + ray.d[i] * oc;
      len2 = len2 + oc * oc;
    end
    rr = sph_r;
    h = dot >>> FRAC_BITS;
    disc = h * h - (len2 - rr * rr);
    if (disc < 0) return res;
    s = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = s | (wide_t'(1) << b);
      if (cand * cand <= disc) s = cand;
    end
    t1 = -h - s;
    t2 = -h + s;
    if (t1 > 0) t = t1;
    else if (t2 > 0) t = t2;
    else return res;
    tdist = (t > I32_MAX) ? I32_MAX : t;
    res.hit = 1;
    res.tdist = tdist[RW-1:0];
    for (int i = 0; i < 3; i++) begin
      hp = ray.o[i];
      hp = sat32(hp + ((tdist * ray.d[i]) >>> FRAC_BITS));
      res.hp[i] = hp[CW-1:0];
      hp = sat32(hp - sph_c[i]);
      res.nrm[i] = hp[CW-1:0];
    end
    return res;
  endfunction

  function automatic logic [CW-1:0] to_fix(real v);
    if (v > 2147483647.0) return 32'h7FFFFFFF;
    if (v < -2147483648.0) return 32'h80000000;
    return $rtoi(v);
  endfunction

  function automatic real urand_pm1();
    return ($urandom / 4294967296.0) * 2.0 - 1.0;
  endfunction

  task automatic push_ray(logic [CW-1:0] ox, oy, oz, dx, dy, dz);
    op_t op;
    op.kind = OP_RAY;
    op.o = '{ox, oy, oz};
    op.d = '{dx, dy, dz};
    op.idx = '0;
    op.data = '0;
    pending.push_back(op);
  endtask

  task automatic push_op(op_kind_t kind, logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
    op_t op;
    op.kind = kind;
    op.o = '{0, 0, 0};
    op.d = '{0, 0, 0};
    op.idx = idx;
    op.data = data;
    pending.push_back(op);
    if (kind == OP_CFG) begin
      if (idx == REG_CENTER_X) plan_c[0] = $itor($signed(data));
      if (idx == REG_CENTER_Y) plan_c[1] = $itor($signed(data));
      if (idx == REG_CENTER_Z) plan_c[2] = $itor($signed(data));
      if (idx == REG_RADIUS) plan_r = $itor({1'b0, data[RW-1:0]});
    end
  endtask

  task automatic push_random_ray();
    real o [3], tg [3], dv [3], len, spread;
    int kind;
    kind = $urandom_range(0, 9);
    spread = plan_r * 4.0 + 262144.0;
    if (spread > 1073741824.0) spread = 1073741824.0;
    if (kind == 7) begin
      push_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      return;
    end
    for (int i = 0; i < 3; i++) begin
      if (kind == 8) o[i] = plan_c[i] + urand_pm1() * plan_r * 0.5;
      else o[i] = plan_c[i] + urand_pm1() * spread;
      tg[i] = plan_c[i] + urand_pm1() * plan_r * 0.9;
      dv[i] = (kind >= 8) ? urand_pm1() : tg[i] - o[i];
    end
    len = $sqrt(dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2]);
    if (len < 1.0e-6) begin
      dv = '{1.0, 0.0, 0.0};
      len = 1.0;
    end
    push_ray(to_fix(o[0]), to_fix(o[1]), to_fix(o[2]), to_fix(dv[0] / len * 65536.0),
             to_fix(dv[1] / len * 65536.0), to_fix(dv[2] / len * 65536.0));
  endtask

  task automatic push_phase(int n);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) push_op(OP_DRAIN, '0, '0);
      push_random_ray();
    end
  endtask

  task automatic chk(string name, logic [CW-1:0] exp_v, logic [CW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver
  int gap = 0;
  int quiet = 0;
  always @(posedge clk) begin
    logic nv_in, nv_cfg;
    op_t op;
    if (rst) begin
      in_valid <= 0;
      cfg_valid <= 0;
      quiet = 0;
    end else begin
      nv_in = in_valid;
      nv_cfg = cfg_valid;
      if (in_valid && in_ready) begin
        op.kind = OP_RAY;
        op.o = '{origin_x, origin_y, origin_z};
        op.d = '{dir_x, dir_y, dir_z};
        expected_hits.push_back(trace_ray(op));
        nv_in = 0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X: sph_c[0] = cfg_data;
          REG_CENTER_Y: sph_c[1] = cfg_data;
          REG_CENTER_Z: sph_c[2] = cfg_data;
          REG_RADIUS:   sph_r = cfg_data[RW-1:0];
          default: ;
        endcase
        nv_cfg = 0;
      end
      if (expected_hits.size() == 0 && !in_valid) quiet++;
      else quiet = 0;
      if (!nv_in && !nv_cfg && pending.size() > 0) begin
        if (gap > 0) begin
          gap--;
        end else if (pending[0].kind == OP_RAY) begin
          op = pending.pop_front();
          origin_x <= op.o[0];
          origin_y <= op.o[1];
          origin_z <= op.o[2];
          dir_x <= op.d[0];
          dir_y <= op.d[1];
          dir_z <= op.d[2];
          nv_in = 1;
          if (pending.size() > 150 && $urandom_range(0, 11) == 0) gap = $urandom_range(1, 19);
        end else if (pending[0].kind == OP_DRAIN) begin
          if (expected_hits.size() == 0) void'(pending.pop_front());
        end else if (quiet >= QUIET_CYC) begin
          op = pending.pop_front();
          cfg_index <= op.idx;
          cfg_data <= op.data;
          nv_cfg = 1;
        end
      end
      in_valid <= nv_in;
      cfg_valid <= nv_cfg;
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk) begin
    logic rdy;
    hit_rec_t e;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          e = expected_hits.pop_front();
          chk("hit", 32'(e.hit), 32'(hit));
          chk("distance", 32'(e.tdist), 32'(distance));
          chk("hit_x", e.hp[0], hit_x);
          chk("hit_y", e.hp[1], hit_y);
          chk("hit_z", e.hp[2], hit_z);
          chk("normal_x", e.nrm[0], normal_x);
          chk("normal_y", e.nrm[1], normal_y);
          chk("normal_z", e.nrm[2], normal_z);
        end
      end
      if (stall > 0) begin
        stall--;
        rdy = 0;
      end else begin
        rdy = 1;
        if (pending.size() > 150 && $urandom_range(0, 11) == 0) stall = $urandom_range(1, 19);
      end
      out_ready <= rdy;
    end
  end

  // watchdog
  int idle_cyc = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  localparam logic [CW-1:0] ONE = 32'h00010000;
  localparam logic [CW-1:0] NEG_ONE = -32'sh00010000;

  initial begin
    // unit sphere at the origin after reset
    push_ray(0, 0, -5 * ONE, 0, 0, ONE);
    push_ray(0, 0, 0, ONE, 0, 0);
    push_ray(0, 0, 5 * ONE, 0, 0, ONE);
    push_ray(0, 5 * ONE, -5 * ONE, 0, 0, ONE);
    push_ray(-5 * ONE, ONE, 0, ONE, 0, 0);
    push_ray(0, NEG_ONE, 3 * ONE, 0, 0, NEG_ONE);
    push_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    push_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    push_ray(0, 0, 0, 0, 0, 0);
    push_ray(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0);
    push_ray(0, 0, 32'h80000000, 0, 0, ONE);
    push_ray(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    push_op(OP_CFG, REG_CENTER_Z, 32'h7FFFFFFF);
    // far hit saturates the distance
    push_ray(0, 0, 32'h80000000, 0, 0, ONE);
    push_ray(0, 0, 32'h80000000, ONE, ONE, ONE);
    push_ray(32'h7FFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF, 0, ONE);

    push_op(OP_CFG, REG_CENTER_X, $urandom_range(0, 1 << 23) - (1 << 22));
    push_op(OP_CFG, REG_CENTER_Y, $urandom_range(0, 1 << 23) - (1 << 22));
    push_op(OP_CFG, REG_CENTER_Z, $urandom_range(0, 1 << 23) - (1 << 22));
    push_op(OP_CFG, REG_RADIUS, $urandom_range(1 << 14, 1 << 20));
    push_phase(330);

    push_op(OP_CFG, REG_CENTER_X, 32'h7FFFFFFF);
    push_op(OP_CFG, REG_CENTER_Y, 32'h80000000);
    push_op(OP_CFG, REG_CENTER_Z, 32'h0);
    push_op(OP_CFG, REG_RADIUS, 32'hFFFFFFFF);
    push_phase(330);

    push_op(OP_CFG, REG_CENTER_X, 32'h80000000);
    push_op(OP_CFG, REG_CENTER_Y, 32'h7FFFFFFF);
    push_op(OP_CFG, REG_CENTER_Z, 32'h80000000);
    push_op(OP_CFG, REG_RADIUS, 32'h0);
    push_phase(330);

    push_op(OP_CFG, 8'd200, 32'h12345678);
    push_op(OP_CFG, REG_CENTER_X, $urandom_range(0, 1 << 27) - (1 << 26));
    push_op(OP_CFG, REG_CENTER_Y, $urandom_range(0, 1 << 27) - (1 << 26));
    push_op(OP_CFG, REG_CENTER_Z, $urandom_range(0, 1 << 27) - (1 << 26));
    push_op(OP_CFG, REG_RADIUS, $urandom_range(1 << 16, 1 << 24));
    push_phase(330);

    push_op(OP_CFG, REG_CENTER_X, 0);
    push_op(OP_CFG, REG_CENTER_Y, 0);
    push_op(OP_CFG, REG_CENTER_Z, 0);
    push_op(OP_CFG, REG_RADIUS, ONE);
    push_phase(330);

    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    while (pending.size() > 0 || in_valid || expected_hits.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
